// File: rtl/fvcs_pkg.sv
// ----------------------------------------------------------------------------
// fvcs_pkg: shared types and constants
// Field widths, register codes and reset values, and the control and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fvcs_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SQ_W       = 31;
  localparam int unsigned SQSUM_W    = 43;
  localparam int unsigned MS_W       = 31;
  localparam int unsigned CNT32_W    = 32;
  localparam int unsigned ACC_W      = 63;
  localparam int unsigned CLIP_THR_W = 15;
  localparam int unsigned SPCH_THR_W = 31;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [MS_W-1:0]       MS_MAX          = 31'd1073741824;
  localparam logic [CLIP_THR_W-1:0] CLIP_THR_RESET  = 15'd32440;
  localparam logic [SPCH_THR_W-1:0] SPCH_THR_RESET  = 31'd107374;

  localparam logic [CFG_IDX_W-1:0]  CFG_CLIP_THR    = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPEECH_THR  = 8'd1;

  typedef struct packed {
    logic clear;
    logic load;
    logic square;
    logic accum;
    logic div_start;
    logic classify;
    logic update;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_full;
  } dp_sts_t;

  typedef struct packed {
    logic [MS_W-1:0]    frame_mean_square;
    logic [MAG_W-1:0]   frame_peak;
    logic               frame_is_speech;
    logic               frame_clipped;
    logic [CNT32_W-1:0] frame_count;
    logic [CNT32_W-1:0] speech_count;
    logic [CNT32_W-1:0] clip_count;
    logic [MAG_W-1:0]   max_peak;
    logic [ACC_W-1:0]   signal_energy_sum;
    logic [ACC_W-1:0]   noise_energy_sum;
  } res_t;

endpackage

// File: rtl/fvcs_if.sv
// ----------------------------------------------------------------------------
// fvcs_if: channel interfaces
// Sample input channel, configuration write channel and result channel.
// ----------------------------------------------------------------------------
interface fvcs_in_if;
  import fvcs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_frame;

  modport source (output valid, command, sample, last_in_frame, input ready);
  modport sink   (input valid, command, sample, last_in_frame, output ready);
  modport mon    (input valid, ready, command, sample, last_in_frame);
endinterface

interface fvcs_cfg_if;
  import fvcs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

interface fvcs_out_if;
  import fvcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [MS_W-1:0]    frame_mean_square;
  logic [MAG_W-1:0]   frame_peak;
  logic               frame_is_speech;
  logic               frame_clipped;
  logic [CNT32_W-1:0] frame_count;
  logic [CNT32_W-1:0] speech_count;
  logic [CNT32_W-1:0] clip_count;
  logic [MAG_W-1:0]   max_peak;
  logic [ACC_W-1:0]   signal_energy_sum;
  logic [ACC_W-1:0]   noise_energy_sum;

  modport source (output valid, frame_mean_square, frame_peak, frame_is_speech,
                  frame_clipped, frame_count, speech_count, clip_count,
                  max_peak, signal_energy_sum, noise_energy_sum, input ready);
  modport sink   (input valid, frame_mean_square, frame_peak, frame_is_speech,
                  frame_clipped, frame_count, speech_count, clip_count,
                  max_peak, signal_energy_sum, noise_energy_sum, output ready);
  modport mon    (input valid, ready, frame_mean_square, frame_peak,
                  frame_is_speech, frame_clipped, frame_count, speech_count,
                  clip_count, max_peak, signal_energy_sum, noise_energy_sum);
endinterface

// File: rtl/fvcs_div.sv
// ----------------------------------------------------------------------------
// fvcs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses after the
// last bit.
// ----------------------------------------------------------------------------
module fvcs_div #(
  parameter int unsigned DIVIDEND_W = 43,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int unsigned STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] a_q, a_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, a_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DIVIDEND_W - 1);
      a_d    = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      a_d   = {a_q[DIVIDEND_W-2:0], ge};
      rem_d = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = a_q;

endmodule

// File: rtl/fvcs_dp.sv
// ----------------------------------------------------------------------------
// fvcs_dp: datapath
// Frame accumulators, mean-square divider, classification, statistics,
// threshold registers and the result register.
// ----------------------------------------------------------------------------
module fvcs_dp #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  fvcs_pkg::ctrl_cmd_t                   cmd_i,
  output fvcs_pkg::dp_sts_t                     sts_o,
  input  logic signed [fvcs_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  last_i,
  input  logic                                  cfg_valid_i,
  input  logic [fvcs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [fvcs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  res_ready_i,
  output logic                                  res_valid_o,
  output fvcs_pkg::res_t                        res_o
);
  import fvcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  logic [CLIP_THR_W-1:0] clip_thr_q;
  logic [SPCH_THR_W-1:0] spch_thr_q;

  logic [MAG_W-1:0]   mag_d, mag_q;
  logic               last_q;
  logic [SQ_W-1:0]    sq_q;
  logic [2*MAG_W-1:0] sq_full;

  logic [SQSUM_W-1:0] fsum_q;
  logic [SQSUM_W:0]   fsum_add;
  logic [CNT_W-1:0]   fcnt_q;
  logic [MAG_W-1:0]   fpeak_q;

  logic [CNT32_W-1:0] total_q, speech_q, clip_q;
  logic [MAG_W-1:0]   opeak_q;
  logic [ACC_W-1:0]   sacc_q, nacc_q;
  logic [ACC_W:0]     sacc_add, nacc_add;

  logic               div_done;
  logic [SQSUM_W-1:0] quot;
  logic [MS_W-1:0]    ms_cap;
  logic [MS_W-1:0]    ms_q;
  logic               is_speech_q, is_clip_q;

  logic [CNT32_W-1:0] total_n, speech_n, clip_n;
  logic [MAG_W-1:0]   opeak_n;
  logic [ACC_W-1:0]   sacc_n, nacc_n;

  logic               out_valid_q;
  res_t               res_q;

  fvcs_div #(
    .DIVIDEND_W (SQSUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (fsum_q),
    .divisor_i  (fcnt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // -32768 maps to 32768 in 16 bits unsigned
  assign mag_d    = sample_i[SAMPLE_W-1] ? (~sample_i + MAG_W'(1)) : sample_i;
  assign sq_full  = mag_q * mag_q;
  assign fsum_add = {1'b0, fsum_q} + (SQSUM_W+1)'(sq_q);
  assign ms_cap   = (quot > SQSUM_W'(MS_MAX)) ? MS_MAX : quot[MS_W-1:0];

  assign sacc_add = {1'b0, sacc_q} + (ACC_W+1)'(ms_q);
  assign nacc_add = {1'b0, nacc_q} + (ACC_W+1)'(ms_q);

  always_comb begin
    total_n  = (&total_q) ? total_q : total_q + CNT32_W'(1);
    speech_n = speech_q;
    clip_n   = clip_q;
    sacc_n   = sacc_q;
    nacc_n   = nacc_q;
    opeak_n  = (fpeak_q > opeak_q) ? fpeak_q : opeak_q;
    if (is_clip_q && !(&clip_q)) begin
      clip_n = clip_q + CNT32_W'(1);
    end
    if (is_speech_q) begin
      if (!(&speech_q)) begin
        speech_n = speech_q + CNT32_W'(1);
      end
      sacc_n = sacc_add[ACC_W] ? {ACC_W{1'b1}} : sacc_add[ACC_W-1:0];
    end else begin
      nacc_n = nacc_add[ACC_W] ? {ACC_W{1'b1}} : nacc_add[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr_q  <= CLIP_THR_RESET;
      spch_thr_q  <= SPCH_THR_RESET;
      fsum_q      <= '0;
      fcnt_q      <= '0;
      fpeak_q     <= '0;
      total_q     <= '0;
      speech_q    <= '0;
      clip_q      <= '0;
      opeak_q     <= '0;
      sacc_q      <= '0;
      nacc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_CLIP_THR) begin
        clip_thr_q <= cfg_data_i[CLIP_THR_W-1:0];
      end
      if (cfg_valid_i && cfg_index_i == CFG_SPEECH_THR) begin
        spch_thr_q <= cfg_data_i[SPCH_THR_W-1:0];
      end
      if (cmd_i.accum) begin
        fsum_q <= fsum_add[SQSUM_W] ? {SQSUM_W{1'b1}} : fsum_add[SQSUM_W-1:0];
        if (fcnt_q < CNT_W'(MAX_FRAME)) begin
          fcnt_q <= fcnt_q + CNT_W'(1);
        end
        if (mag_q > fpeak_q) begin
          fpeak_q <= mag_q;
        end
      end
      if (res_valid_o && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        total_q  <= '0;
        speech_q <= '0;
        clip_q   <= '0;
        opeak_q  <= '0;
        sacc_q   <= '0;
        nacc_q   <= '0;
      end else if (cmd_i.update) begin
        total_q     <= total_n;
        speech_q    <= speech_n;
        clip_q      <= clip_n;
        opeak_q     <= opeak_n;
        sacc_q      <= sacc_n;
        nacc_q      <= nacc_n;
        fsum_q      <= '0;
        fcnt_q      <= '0;
        fpeak_q     <= '0;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= mag_d;
      last_q <= last_i;
    end
    if (cmd_i.square) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
    if (cmd_i.classify) begin
      ms_q        <= ms_cap;
      is_speech_q <= ms_cap > spch_thr_q;
      is_clip_q   <= fpeak_q > MAG_W'(clip_thr_q);
    end
    if (cmd_i.update) begin
      res_q.frame_mean_square <= ms_q;
      res_q.frame_peak        <= fpeak_q;
      res_q.frame_is_speech   <= is_speech_q;
      res_q.frame_clipped     <= is_clip_q;
      res_q.frame_count       <= total_n;
      res_q.speech_count      <= speech_n;
      res_q.clip_count        <= clip_n;
      res_q.max_peak          <= opeak_n;
      res_q.signal_energy_sum <= sacc_n;
      res_q.noise_energy_sum  <= nacc_n;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_full = out_valid_q;
  assign res_valid_o    = out_valid_q;
  assign res_o          = res_q;

endmodule

// File: rtl/fvcs_ctrl.sv
// ----------------------------------------------------------------------------
// fvcs_ctrl: sequencing controller
// Steps each sample item through square and accumulate and, on a frame end,
// the divide, classify and update phases; clear items act in the idle state.
// ----------------------------------------------------------------------------
module fvcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  input  fvcs_pkg::dp_sts_t    sts_i,
  output fvcs_pkg::ctrl_cmd_t  cmd_o
);
  import fvcs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_CLS    = 3'd5;
  localparam logic [2:0] S_UPD    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i) begin
            cmd_o.clear = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd_o.square = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.last ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CLS;
        end
      end
      S_CLS: begin
        cmd_o.classify = 1'b1;
        state_d        = S_UPD;
      end
      S_UPD: begin
        if (!sts_i.out_full) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/frame_level_vad_clip_stats_core.sv
// ----------------------------------------------------------------------------
// frame_level_vad_clip_stats_core: frame energy VAD and clip statistics
//
//   channel  dir  modport  carries
//   in_i     in   sink     command, sample, last_in_frame
//   cfg_i    in   sink     index, data (0 clip_threshold, 1 speech_threshold)
//   res_o    out  source   frame result and running statistics
//
// A clear item is taken in the idle state; a sample item is loaded, squared and
// accumulated. A frame-closing sample then goes on to a divider start, the
// 43-bit bit-serial divide that forms the mean square, classify and update.
// rst_ni clears the frame accumulators and statistics and loads the
// threshold reset values. The result register holds a finished frame while
// following samples are taken; the next frame end waits until it is read.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
module frame_level_vad_clip_stats_core #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fvcs_in_if.sink           in_i,
  fvcs_cfg_if.sink          cfg_i,
  fvcs_out_if.source        res_o
);
  import fvcs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  res_t      res;
  logic      res_valid;
  logic      in_ready;

  fvcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  fvcs_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (in_i.sample),
    .last_i      (in_i.last_in_frame),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid             = res_valid;
  assign res_o.frame_mean_square = res.frame_mean_square;
  assign res_o.frame_peak        = res.frame_peak;
  assign res_o.frame_is_speech   = res.frame_is_speech;
  assign res_o.frame_clipped     = res.frame_clipped;
  assign res_o.frame_count       = res.frame_count;
  assign res_o.speech_count      = res.speech_count;
  assign res_o.clip_count        = res.clip_count;
  assign res_o.max_peak          = res.max_peak;
  assign res_o.signal_energy_sum = res.signal_energy_sum;
  assign res_o.noise_energy_sum  = res.noise_energy_sum;

endmodule

// File: rtl/fvcs_checker.sv
// ----------------------------------------------------------------------------
// fvcs_checker: port-level checks
// Result channel hold rule, value ranges, consistency of the reported
// statistics and the input and register handshakes.
// ----------------------------------------------------------------------------
module fvcs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  fvcs_in_if.sink    in_i,
  fvcs_cfg_if.sink   cfg_i,
  fvcs_out_if.source res_o
);
  import fvcs_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=>
      res_o.valid && $stable(res_o.frame_mean_square) && $stable(res_o.frame_count))
    else $error("result changed while stalled");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_mean_square <= MS_MAX &&
      res_o.frame_peak <= res_o.max_peak && res_o.max_peak <= 16'd32768)
    else $error("result value out of range");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.frame_count != '0 &&
      res_o.speech_count <= res_o.frame_count &&
      res_o.clip_count <= res_o.frame_count)
    else $error("frame counters inconsistent");

  // a sample item keeps the input busy while it is squared and summed
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && !in_i.command |=> !in_i.ready)
    else $error("input ready right after a sample item");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.ready)
    else $error("register channel not ready");

endmodule

bind frame_level_vad_clip_stats_core fvcs_checker u_fvcs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .cfg_i  (cfg_i),
  .res_o  (res_o)
);

// File: tb/frame_level_vad_clip_stats_check.sv
// ----------------------------------------------------------------------------
// frame_level_vad_clip_stats_check: frame statistics predictor and comparator
// Watches the sample, register and result channels. Tracks thresholds and
// per-frame state, forms the expected result of every closed frame and
// compares each result item field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module frame_level_vad_clip_stats_check #(
  parameter int unsigned MAX_FRAME = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fvcs_in_if.mon      in_m,
  fvcs_cfg_if.mon     cfg_m,
  fvcs_out_if.mon     res_m,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned frames_checked_o,
  output int unsigned speech_seen_o,
  output int unsigned clipped_seen_o
);
  import fvcs_pkg::*;

  localparam logic [63:0] SQSUM_CAP = (64'd1 << SQSUM_W) - 64'd1;
  localparam logic [63:0] ACC_CAP   = (64'd1 << ACC_W) - 64'd1;

  logic [CLIP_THR_W-1:0] clip_thr;
  logic [SPCH_THR_W-1:0] speech_thr;

  logic [SQSUM_W-1:0]    sq_sum;
  int unsigned           n_samples;
  logic [MAG_W-1:0]      peak_open;
  logic [CNT32_W-1:0]    n_total;
  logic [CNT32_W-1:0]    n_speech;
  logic [CNT32_W-1:0]    n_clip;
  logic [MAG_W-1:0]      peak_all;
  logic [ACC_W-1:0]      speech_acc;
  logic [ACC_W-1:0]      noise_acc;

  res_t                  due_frames_q[$];
  int unsigned           n_fail = 0;
  int unsigned           n_checked = 0;
  int unsigned           n_speech_seen = 0;
  int unsigned           n_clipped_seen = 0;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] cap);
    if (a >= cap || b > cap - a) return cap;
    return a + b;
  endfunction

  function automatic logic [CNT32_W-1:0] bump(input logic [CNT32_W-1:0] v);
    return (v == '1) ? v : v + CNT32_W'(1);
  endfunction

  task automatic note_mismatch(input string what);
    $display("%0t mismatch, frame %0d: %s", $time, n_checked, what);
    n_fail++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic clear_stats();
    n_total    = '0;
    n_speech   = '0;
    n_clip     = '0;
    peak_all   = '0;
    speech_acc = '0;
    noise_acc  = '0;
  endtask

  task automatic accumulate_item(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                                 input logic lst);
    logic [MAG_W:0] mag;
    logic [63:0]    ms;
    res_t           r;
    if (cmd) begin
      clear_stats();
      return;
    end
    mag = smp[SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    sq_sum = SQSUM_W'(sat_add(64'(sq_sum), 64'(mag) * 64'(mag), SQSUM_CAP));
    if (n_samples < MAX_FRAME) n_samples++;
    if (mag[MAG_W-1:0] > peak_open) peak_open = mag[MAG_W-1:0];
    if (!lst) return;

    ms = 64'(sq_sum) / 64'(n_samples);
    if (ms > 64'(MS_MAX)) ms = 64'(MS_MAX);
    r.frame_mean_square = ms[MS_W-1:0];
    r.frame_peak        = peak_open;
    r.frame_is_speech   = ms > 64'(speech_thr);
    r.frame_clipped     = peak_open > MAG_W'(clip_thr);

    n_total = bump(n_total);
    if (peak_open > peak_all) peak_all = peak_open;
    if (r.frame_clipped) n_clip = bump(n_clip);
    if (r.frame_is_speech) begin
      n_speech   = bump(n_speech);
      speech_acc = ACC_W'(sat_add(64'(speech_acc), ms, ACC_CAP));
    end else begin
      noise_acc = ACC_W'(sat_add(64'(noise_acc), ms, ACC_CAP));
    end

    r.frame_count       = n_total;
    r.speech_count      = n_speech;
    r.clip_count        = n_clip;
    r.max_peak          = peak_all;
    r.signal_energy_sum = speech_acc;
    r.noise_energy_sum  = noise_acc;
    due_frames_q.push_back(r);

    sq_sum    = '0;
    n_samples = 0;
    peak_open = '0;
  endtask

  task automatic compare_result();
    res_t want;
    if (due_frames_q.size() == 0) begin
      note_mismatch("result item with no frame due");
      return;
    end
    want = due_frames_q.pop_front();
    check_field("frame_mean_square", 64'(res_m.frame_mean_square),
                64'(want.frame_mean_square));
    check_field("frame_peak", 64'(res_m.frame_peak), 64'(want.frame_peak));
    check_field("frame_is_speech", 64'(res_m.frame_is_speech), 64'(want.frame_is_speech));
    check_field("frame_clipped", 64'(res_m.frame_clipped), 64'(want.frame_clipped));
    check_field("frame_count", 64'(res_m.frame_count), 64'(want.frame_count));
    check_field("speech_count", 64'(res_m.speech_count), 64'(want.speech_count));
    check_field("clip_count", 64'(res_m.clip_count), 64'(want.clip_count));
    check_field("max_peak", 64'(res_m.max_peak), 64'(want.max_peak));
    check_field("signal_energy_sum", 64'(res_m.signal_energy_sum),
                64'(want.signal_energy_sum));
    check_field("noise_energy_sum", 64'(res_m.noise_energy_sum),
                64'(want.noise_energy_sum));
    if (want.frame_is_speech) n_speech_seen++;
    if (want.frame_clipped) n_clipped_seen++;
    n_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr   = CLIP_THR_RESET;
      speech_thr = SPCH_THR_RESET;
      sq_sum     = '0;
      n_samples  = 0;
      peak_open  = '0;
      clear_stats();
      due_frames_q.delete();
    end else begin
      if (res_m.valid && res_m.ready) compare_result();
      if (cfg_m.valid && cfg_m.ready) begin
        if (cfg_m.index == CFG_CLIP_THR) clip_thr = cfg_m.data[CLIP_THR_W-1:0];
        else if (cfg_m.index == CFG_SPEECH_THR) speech_thr = cfg_m.data[SPCH_THR_W-1:0];
      end
      if (in_m.valid && in_m.ready)
        accumulate_item(in_m.command, in_m.sample, in_m.last_in_frame);
    end
    pending_o        <= due_frames_q.size();
    fail_count_o     <= n_fail;
    frames_checked_o <= n_checked;
    speech_seen_o    <= n_speech_seen;
    clipped_seen_o   <= n_clipped_seen;
  end

endmodule

// File: tb/frame_level_vad_clip_stats_core_tb.sv
// ----------------------------------------------------------------------------
// frame_level_vad_clip_stats_core_tb: testbench for the frame VAD/clip core
// Directed frames at the sample and threshold extremes, then random frames of
// mixed length and level over a sweep of threshold settings, with clears
// mixed in, bursty input and a stalling result side.
// Results are checked by the companion check module.
// ----------------------------------------------------------------------------
module frame_level_vad_clip_stats_core_tb;
  import fvcs_pkg::*;

  localparam int unsigned MAX_FRAME    = 4096;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned HOLD_PHASE   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_SPEECH_THR + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fvcs_in_if  in_if ();
  fvcs_cfg_if cfg_if ();
  fvcs_out_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned frames_checked;
  int unsigned speech_seen;
  int unsigned clipped_seen;

  int unsigned items_sent  = 0;
  int unsigned clears_sent = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_max     = 0;
  bit          hold_req    = 1'b0;

  always #2 clk_i = ~clk_i;

  frame_level_vad_clip_stats_core #(
    .MAX_FRAME (MAX_FRAME)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  frame_level_vad_clip_stats_check #(
    .MAX_FRAME (MAX_FRAME)
  ) u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_m             (in_if),
    .cfg_m            (cfg_if),
    .res_m            (res_if),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .frames_checked_o (frames_checked),
    .speech_seen_o    (speech_seen),
    .clipped_seen_o   (clipped_seen)
  );

  task automatic push_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                           input logic lst);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid         <= 1'b1;
    in_if.command       <= cmd;
    in_if.sample        <= smp;
    in_if.last_in_frame <= lst;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (cmd) clears_sent++;
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic send_frame(input int unsigned len, input int unsigned shift,
                            input bit with_clears);
    logic signed [SAMPLE_W-1:0] s;
    for (int unsigned i = 0; i < len; i++) begin
      if (with_clears && $urandom_range(0, 63) == 0)
        push_item(1'b1, 16'($urandom()), 1'($urandom()));
      s = 16'($urandom());
      s = s >>> shift;
      if ($urandom_range(0, 31) == 0) s = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      push_item(1'b0, s, i == len - 1);
    end
  endtask

  // wait for every frame result, then for the tail of any sample still in work
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned left;
    int unsigned pct;
    bit          held;
    held = 1'b0;
    res_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      left = $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: pct = 100;
        1: pct = 70;
        2: pct = 30;
        default: pct = 8;
      endcase
      repeat (left) begin
        @(posedge clk_i);
        if (hold_req && !held) begin
          held = 1'b1;
          res_if.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        res_if.ready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
    $display("frame_level_vad_clip_stats_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned r;
    int unsigned len;
    in_if.valid         = 1'b0;
    in_if.command       = 1'b0;
    in_if.sample        = '0;
    in_if.last_in_frame = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at reset thresholds
    gap_max = 2;
    push_item(1'b0, 16'sh8000, 1'b1);
    push_item(1'b0, 16'sh7FFF, 1'b1);
    push_item(1'b0, 16'sd0, 1'b1);
    push_item(1'b1, 16'sh7FFF, 1'b1);
    push_item(1'b0, 16'sd1, 1'b0);
    push_item(1'b0, -16'sd1, 1'b0);
    push_item(1'b0, 16'sd2, 1'b1);
    push_item(1'b0, 16'sd100, 1'b0);
    push_item(1'b1, 16'sh8000, 1'b0);   // clear inside an open frame
    push_item(1'b0, -16'sd100, 1'b1);
    push_item(1'b0, 16'sh8000, 1'b0);
    push_item(1'b0, 16'sh8000, 1'b0);
    push_item(1'b0, 16'sh7FFF, 1'b1);
    push_item(1'b0, 16'sd328, 1'b1);    // just above speech threshold
    push_item(1'b0, 16'sd327, 1'b1);    // just below
    push_item(1'b0, 16'sd32440, 1'b1);  // peak equal to clip threshold
    push_item(1'b0, -16'sd32441, 1'b1);
    push_item(1'b1, 16'sd0, 1'b0);
    push_item(1'b0, 16'sd5, 1'b1);
    settle();

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      case (p)
        0: ;
        1: begin
          write_reg(CFG_CLIP_THR, '0);
          write_reg(CFG_SPEECH_THR, '0);
        end
        2: begin
          write_reg(CFG_CLIP_THR, 32'd32767);
          write_reg(CFG_SPEECH_THR, 32'd1073741824);
        end
        3: begin
          write_reg(CFG_CLIP_THR, '1);
          write_reg(CFG_SPEECH_THR, '1);
          write_reg(CFG_UNUSED_LO, $urandom());
          write_reg(CFG_UNUSED_HI, $urandom());
        end
        default: begin
          write_reg(CFG_CLIP_THR, $urandom_range(0, 32767));
          write_reg(CFG_SPEECH_THR, $urandom_range(0, 1 << 30) >> $urandom_range(0, 20));
        end
      endcase
      cfg_if.valid <= 1'b0;
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(4, 40);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      if (p % 2 == 1) push_item(1'b1, 16'($urandom()), 1'($urandom()));
      target = items_sent + RANDOM_ITEMS / N_PHASES;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(1, 6) :
              (r < 97) ? $urandom_range(7, 40) : $urandom_range(41, 300);
        send_frame(len, $urandom_range(0, 15), 1'b1);
      end
      settle();
    end

    $display("covered %0d items (%0d clears) over %0d threshold settings",
             items_sent, clears_sent, N_PHASES);
    $display("checked %0d frame results: %0d speech, %0d clipped",
             frames_checked, speech_seen, clipped_seen);
    if (fail_count == 0 && pending == 0)
      $display("frame_level_vad_clip_stats_core_tb passed");
    else
      $display("frame_level_vad_clip_stats_core_tb failed");
    $finish;
  end

endmodule
